/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants and types for the rotation matrix to quaternion unit.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Default number of fraction bits (Q2.14)
    localparam int FRAC_BITS_DEF = 14;

    // Matrix entry width, fixed by the input format
    localparam int IN_W       = 16;
    localparam int N_ENTRIES  = 9;
    localparam int N_LANES    = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int THR_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NEGATE_CONV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_THR    = 1'b1;

    // Per-lane diagonal sign pattern, bit set = subtract
    // bit 0: m00, bit 1: m11, bit 2: m22
    // lane 0: scalar, lanes 1..3: x, y, z
    localparam logic [N_LANES-1:0][2:0] LANE_SUBTRACT = {3'b011, 3'b101, 3'b110, 3'b000};

    // Per-word sign information that travels beside the lanes
    typedef struct packed {
        logic [2:0] neg;   // negate x, y, z from off-diagonal compares
        logic       conv;  // convention sign is -1
    } t_side;

endpackage

/* rtl/rmq_root_step.sv */
// ----------------------------------------------------------------------------
// rmq_root_step
// One registered digit step of the square root: consumes two radicand bits,
// produces one root bit and the updated remainder.
// ----------------------------------------------------------------------------
module rmq_root_step #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [1:0]           i_pair,
    input  logic [FRAC_BITS:0]   i_root,
    input  logic [FRAC_BITS+2:0] i_rem,
    input  logic                 i_bad,
    output logic [FRAC_BITS:0]   o_root,
    output logic [FRAC_BITS+2:0] o_rem,
    output logic                 o_bad
);

    localparam int NS  = FRAC_BITS + 1;
    localparam int RMW = NS + 2;

    logic [RMW+1:0] tmp;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           fits;
    logic [NS-1:0]  n_root;
    logic [RMW-1:0] n_rem;
    logic [NS-1:0]  r_root;
    logic [RMW-1:0] r_rem;
    logic           r_bad;

    // trial subtract of 4*root+1 from the shifted remainder
    always_comb begin
        tmp    = {i_rem, i_pair};
        trial  = {2'b00, i_root, 2'b01};
        diff   = tmp - trial;
        fits   = (tmp >= trial);
        n_rem  = fits ? diff[RMW-1:0] : tmp[RMW-1:0];
        n_root = {i_root[NS-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
            r_rem  <= n_rem;
            r_bad  <= i_bad;
        end
    end

    assign o_root = r_root;
    assign o_rem  = r_rem;
    assign o_bad  = r_bad;

endmodule

/* rtl/rmq_lane.sv */
// ----------------------------------------------------------------------------
// rmq_lane
// One quaternion component magnitude: radicand, threshold and sign check,
// pipelined digit-by-digit square root, round to nearest.
// ----------------------------------------------------------------------------
module rmq_lane #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic [FRAC_BITS+2:0]              i_en,       // one load enable per stage
    input  logic [rmq_pkg::THR_W-1:0]         i_zero_thr,
    input  logic [2:0]                        i_subtract, // m00, m11, m22 from bit 0
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m00,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m11,
    input  logic signed [rmq_pkg::IN_W-1:0]   i_m22,
    output logic [FRAC_BITS:0]                o_mag,
    output logic                              o_bad
);

    localparam int NS  = FRAC_BITS + 1;          // root bits and digit steps
    localparam int XW  = 2 * NS;                 // root operand width
    localparam int RMW = NS + 2;                 // remainder width
    localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int CW  = FRAC_BITS + 3;          // clamped radicand width
    localparam int EXT = RW - rmq_pkg::IN_W;

    localparam logic signed [RW-1:0] ONE   = RW'(1) << FRAC_BITS;
    localparam logic        [RW-1:0] CLAMP = RW'(1) << (FRAC_BITS + 2);

    logic signed [RW-1:0] t00, t11, t22, rad;
    logic        [RW-1:0] rad_mag;
    logic                 below, neg;
    logic        [CW-1:0] n_rad;
    logic                 n_bad;

    logic [XW-1:0]  r_x [0:NS-1];
    logic           r_bad0;
    logic [NS-1:0]  root_s [0:NS-1];
    logic [RMW-1:0] rem_s  [0:NS-1];
    logic           bad_s  [0:NS-1];

    logic           round_up;
    logic [NS-1:0]  r_mag;
    logic           r_bad;

    // radicand, threshold and negative check
    always_comb begin
        t00 = {{EXT{i_m00[rmq_pkg::IN_W-1]}}, i_m00};
        t11 = {{EXT{i_m11[rmq_pkg::IN_W-1]}}, i_m11};
        t22 = {{EXT{i_m22[rmq_pkg::IN_W-1]}}, i_m22};
        rad = ONE + (i_subtract[0] ? -t00 : t00)
                  + (i_subtract[1] ? -t11 : t11)
                  + (i_subtract[2] ? -t22 : t22);
        neg     = rad[RW-1];
        rad_mag = neg ? RW'(-rad) : RW'(rad);
        below   = (rad_mag < RW'(i_zero_thr));
        n_bad   = !below && neg;
        // anything at or above 4.0 already rounds to a full-scale root
        if (below || neg) begin
            n_rad = '0;
        end else if (rad_mag > CLAMP) begin
            n_rad = CLAMP[CW-1:0];
        end else begin
            n_rad = rad_mag[CW-1:0];
        end
    end

    // front stage: scaled root operand
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0] <= {1'b0, n_rad, {(FRAC_BITS-2){1'b0}}};
            r_bad0 <= n_bad;
        end
    end

    // operand shift line, two bits consumed per stage
    for (genvar k = 1; k < NS; k++) begin : g_xline
        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_x[k] <= r_x[k-1] << 2;
            end
        end
    end

    // digit steps
    for (genvar k = 0; k < NS; k++) begin : g_step
        if (k == 0) begin : g_first
            rmq_root_step #(.FRAC_BITS(FRAC_BITS)) u_step (
                .i_clk  (i_clk),
                .i_en   (i_en[1]),
                .i_pair (r_x[0][XW-1:XW-2]),
                .i_root ('0),
                .i_rem  ('0),
                .i_bad  (r_bad0),
                .o_root (root_s[0]),
                .o_rem  (rem_s[0]),
                .o_bad  (bad_s[0])
            );
        end else begin : g_next
            rmq_root_step #(.FRAC_BITS(FRAC_BITS)) u_step (
                .i_clk  (i_clk),
                .i_en   (i_en[k+1]),
                .i_pair (r_x[k][XW-1:XW-2]),
                .i_root (root_s[k-1]),
                .i_rem  (rem_s[k-1]),
                .i_bad  (bad_s[k-1]),
                .o_root (root_s[k]),
                .o_rem  (rem_s[k]),
                .o_bad  (bad_s[k])
            );
        end
    end

    // round to nearest: remainder above root means the upper neighbor is closer
    assign round_up = (rem_s[NS-1] > {2'b00, root_s[NS-1]});

    always_ff @(posedge i_clk) begin
        if (i_en[NS+1]) begin
            r_mag <= root_s[NS-1] + NS'(round_up);
            r_bad <= bad_s[NS-1];
        end
    end

    assign o_mag = r_mag;
    assign o_bad = r_bad;

endmodule

/* rtl/rmq_merge.sv */
// ----------------------------------------------------------------------------
// rmq_merge
// Combines the four lane magnitudes: vector signs, convention sign and the
// flip to a non-negative scalar; holds the output word.
// ----------------------------------------------------------------------------
module rmq_merge #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_en,
    input  logic [rmq_pkg::N_LANES-1:0][FRAC_BITS:0]     i_mag,
    input  logic [rmq_pkg::N_LANES-1:0]                  i_bad,
    input  rmq_pkg::t_side                               i_side,
    output logic [FRAC_BITS:0]                           o_q_scalar,
    output logic signed [FRAC_BITS+1:0]                  o_q_x,
    output logic signed [FRAC_BITS+1:0]                  o_q_y,
    output logic signed [FRAC_BITS+1:0]                  o_q_z,
    output logic                                         o_bad
);

    localparam int VW = FRAC_BITS + 2;

    logic                 flip;
    logic [VW-1:0]        ext_x, ext_y, ext_z;
    logic signed [VW-1:0] n_x, n_y, n_z;

    logic [FRAC_BITS:0]   r_q_scalar;
    logic signed [VW-1:0] r_q_x, r_q_y, r_q_z;
    logic                 r_bad;

    // a negative scalar flips the whole quaternion; a zero scalar never does
    always_comb begin
        flip  = i_side.conv && (i_mag[0] != '0);
        ext_x = {1'b0, i_mag[1]};
        ext_y = {1'b0, i_mag[2]};
        ext_z = {1'b0, i_mag[3]};
        n_x   = (i_side.neg[0] ^ flip) ? -ext_x : ext_x;
        n_y   = (i_side.neg[1] ^ flip) ? -ext_y : ext_y;
        n_z   = (i_side.neg[2] ^ flip) ? -ext_z : ext_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q_scalar <= i_mag[0];
            r_q_x      <= n_x;
            r_q_y      <= n_y;
            r_q_z      <= n_z;
            r_bad      <= |i_bad;
        end
    end

    assign o_q_scalar = r_q_scalar;
    assign o_q_x      = r_q_x;
    assign o_q_y      = r_q_y;
    assign o_q_z      = r_q_z;
    assign o_bad      = r_bad;

endmodule

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix in fixed point to a unit quaternion with a
// non-negative scalar part, using four square root lanes side by side.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the output is not stalled; depth is
//   set by the square root pipeline, one root bit per stage in each of the
//   four lanes.
// Reset: i_rst_n synchronous, active low; clears stage valids and both
//   configuration registers (convention +1, zero threshold 0).
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // configuration write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rmq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [rmq_pkg::CFG_DATA_W-1:0]         i_cfg_data,

    // input stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0, 16 bits each
    input  logic [rmq_pkg::N_ENTRIES*rmq_pkg::IN_W-1:0] s_axis_tdata,

    // output stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // q_scalar (FRAC_BITS+1), q_x, q_y, q_z (FRAC_BITS+2 each) from bit 0,
    // zero filled to whole bytes
    output logic [((4*FRAC_BITS+7+7)/8)*8-1:0]     m_axis_tdata,
    // bad_radicand
    output logic [0:0]                             m_axis_tuser
);

    localparam int IN_W     = rmq_pkg::IN_W;
    localparam int N_LANES  = rmq_pkg::N_LANES;
    localparam int D        = FRAC_BITS + 3;   // stages ahead of the output word
    localparam int VW       = FRAC_BITS + 2;
    localparam int OUT_BITS = 4 * FRAC_BITS + 7;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    logic                              r_negate_conv;
    logic [rmq_pkg::THR_W-1:0]         r_zero_thr;

    logic signed [IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    rmq_pkg::t_side         n_side;
    rmq_pkg::t_side         r_side [0:D-1];

    logic [D:0]             stg_rdy;
    logic [D:0]             r_vld;

    logic [N_LANES-1:0][FRAC_BITS:0] lane_mag;
    logic [N_LANES-1:0]              lane_bad;

    logic [FRAC_BITS:0]     q_scalar;
    logic signed [VW-1:0]   q_x, q_y, q_z;
    logic                   bad_radicand;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_negate_conv <= 1'b0;
            r_zero_thr    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rmq_pkg::CFG_NEGATE_CONV: r_negate_conv <= i_cfg_data[0];
                rmq_pkg::CFG_ZERO_THR:    r_zero_thr    <= i_cfg_data[rmq_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input word
    assign m00 = s_axis_tdata[0*IN_W +: IN_W];
    assign m01 = s_axis_tdata[1*IN_W +: IN_W];
    assign m02 = s_axis_tdata[2*IN_W +: IN_W];
    assign m10 = s_axis_tdata[3*IN_W +: IN_W];
    assign m11 = s_axis_tdata[4*IN_W +: IN_W];
    assign m12 = s_axis_tdata[5*IN_W +: IN_W];
    assign m20 = s_axis_tdata[6*IN_W +: IN_W];
    assign m21 = s_axis_tdata[7*IN_W +: IN_W];
    assign m22 = s_axis_tdata[8*IN_W +: IN_W];

    // vector signs from the off-diagonal pairs
    always_comb begin
        n_side.neg[0] = (m21 < m12);
        n_side.neg[1] = (m02 < m20);
        n_side.neg[2] = (m10 < m01);
        n_side.conv   = r_negate_conv;
    end

    // stage handshake: a stage loads when empty or when its successor moves
    assign stg_rdy[D] = !r_vld[D] || m_axis_tready;
    for (genvar k = 0; k < D; k++) begin : g_rdy
        assign stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k <= D; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stg_rdy[0];
    assign m_axis_tvalid = r_vld[D];

    // sign information rides beside the lanes
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_side[0] <= n_side;
        end
        for (int k = 1; k < D; k++) begin
            if (stg_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // four component lanes
    for (genvar i = 0; i < N_LANES; i++) begin : g_lane
        rmq_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk      (i_clk),
            .i_en       (stg_rdy[D-1:0]),
            .i_zero_thr (r_zero_thr),
            .i_subtract (rmq_pkg::LANE_SUBTRACT[i]),
            .i_m00      (m00),
            .i_m11      (m11),
            .i_m22      (m22),
            .o_mag      (lane_mag[i]),
            .o_bad      (lane_bad[i])
        );
    end

    // merge and output word
    rmq_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .i_clk      (i_clk),
        .i_en       (stg_rdy[D]),
        .i_mag      (lane_mag),
        .i_bad      (lane_bad),
        .i_side     (r_side[D-1]),
        .o_q_scalar (q_scalar),
        .o_q_x      (q_x),
        .o_q_y      (q_y),
        .o_q_z      (q_z),
        .o_bad      (bad_radicand)
    );

    assign m_axis_tdata = OUT_W'({q_z, q_y, q_x, q_scalar});
    assign m_axis_tuser = bad_radicand;

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rotation_matrix_to_quaternion_unit. Matrix words go
// in on the slave stream with random gaps. Every accepted word is run through
// a local fixed-point predictor, and the quaternion it should give is queued.
// Each quaternion taken from the master stream, which stalls at random, is
// checked against the oldest queued quaternion. The bench covers directed
// corner matrices, then random rotations, noisy and out-of-range matrices
// under several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int FRAC       = rmq_pkg::FRAC_BITS_DEF;
    localparam int IN_W       = rmq_pkg::IN_W;
    localparam int SW         = FRAC + 1;
    localparam int VW         = FRAC + 2;
    localparam int OUT_W      = ((4*FRAC+7+7)/8)*8;
    localparam int LATENCY    = FRAC + 4;
    localparam longint ONE    = longint'(1) << FRAC;
    localparam int TIMEOUT_NS = 5_000_000;

    typedef logic [rmq_pkg::N_ENTRIES*IN_W-1:0] t_matrix_word;

    typedef struct packed {
        logic          bad;
        logic [VW-1:0] qz;
        logic [VW-1:0] qy;
        logic [VW-1:0] qx;
        logic [SW-1:0] scalar;
    } t_quat;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rmq_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rmq_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [rmq_pkg::N_ENTRIES*IN_W-1:0] s_axis_tdata;   // m00 .. m22, 16 bits each
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [OUT_W-1:0]               m_axis_tdata;       // q_scalar, q_x, q_y, q_z, pad
    logic [0:0]                     m_axis_tuser;       // bad_radicand

    // predictor copy of the registers
    bit     conv_neg;
    longint zero_thr;

    t_quat  pending_quats [$];
    int     mismatches;
    bit     send_steady;
    bit     take_steady;

    rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FRAC)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // half square root of one radicand, rounded to nearest, with threshold
    function automatic longint half_root(input longint rad, inout bit bad);
        longint mag;
        longint n;
        longint c;
        longint t;
        mag = (rad < 0) ? -rad : rad;
        if (mag < zero_thr) return 0;
        if (rad < 0) begin
            bad = 1'b1;
            return 0;
        end
        n = rad << (FRAC - 2);
        c = 0;
        for (int b = 20; b >= 0; b--) begin
            t = c | (longint'(1) << b);
            if (t * t <= n) c = t;
        end
        if (n - c * c > c) c = c + 1;
        if (c > ONE) c = ONE;
        return c;
    endfunction

    function automatic t_quat predict_quaternion(input t_matrix_word w);
        longint e [9];
        longint s, x, y, z;
        bit     bad;
        t_quat  q;
        for (int i = 0; i < 9; i++) e[i] = longint'($signed(w[i*IN_W +: IN_W]));
        bad = 1'b0;
        s = half_root(ONE + e[0] + e[4] + e[8], bad);
        x = half_root(ONE + e[0] - e[4] - e[8], bad);
        y = half_root(ONE - e[0] + e[4] - e[8], bad);
        z = half_root(ONE - e[0] - e[4] + e[8], bad);
        if (conv_neg) s = -s;
        // vector signs from the off-diagonal pairs
        if (e[7] < e[5]) x = -x;
        if (e[2] < e[6]) y = -y;
        if (e[3] < e[1]) z = -z;
        // keep the scalar non-negative
        if (s < 0) begin
            s = -s;
            x = -x;
            y = -y;
            z = -z;
        end
        q.scalar = s[SW-1:0];
        q.qx     = x[VW-1:0];
        q.qy     = y[VW-1:0];
        q.qz     = z[VW-1:0];
        q.bad    = bad;
        return q;
    endfunction

    function automatic string quat_text(input t_quat q);
        return $sformatf("s=%0d x=%0d y=%0d z=%0d bad=%0d", q.scalar,
                         $signed(q.qx), $signed(q.qy), $signed(q.qz), q.bad);
    endfunction

    // ------------------------------------------------------------------------
    // Matrix builders
    // ------------------------------------------------------------------------

    function automatic t_matrix_word mat(input int a00, input int a01, input int a02,
                                         input int a10, input int a11, input int a12,
                                         input int a20, input int a21, input int a22);
        int           v [9];
        t_matrix_word w;
        v = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
        for (int i = 0; i < 9; i++) w[i*IN_W +: IN_W] = v[i][IN_W-1:0];
        return w;
    endfunction

    // proper rotation from a random quaternion, entries jittered by +-noise
    function automatic t_matrix_word rotation_word(input int noise);
        real          qv [4];
        real          nrm, a, b, c, d;
        real          r [9];
        t_matrix_word w;
        int           v;
        for (int i = 0; i < 4; i++) begin
            qv[i] = real'(int'($urandom_range(0, 2000)) - 1000);
            if ($urandom_range(0, 4) == 0) qv[i] = 0.0;
        end
        nrm = $sqrt(qv[0]*qv[0] + qv[1]*qv[1] + qv[2]*qv[2] + qv[3]*qv[3]);
        if (nrm == 0.0) begin
            qv[0] = 1.0;
            nrm   = 1.0;
        end
        a = qv[0] / nrm;
        b = qv[1] / nrm;
        c = qv[2] / nrm;
        d = qv[3] / nrm;
        r[0] = 1.0 - 2.0*(c*c + d*d);
        r[1] = 2.0*(b*c - a*d);
        r[2] = 2.0*(b*d + a*c);
        r[3] = 2.0*(b*c + a*d);
        r[4] = 1.0 - 2.0*(b*b + d*d);
        r[5] = 2.0*(c*d - a*b);
        r[6] = 2.0*(b*d - a*c);
        r[7] = 2.0*(c*d + a*b);
        r[8] = 1.0 - 2.0*(b*b + c*c);
        for (int i = 0; i < 9; i++) begin
            v = int'(r[i] * real'(ONE)) + int'($urandom_range(0, 2*noise)) - noise;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            w[i*IN_W +: IN_W] = v[IN_W-1:0];
        end
        return w;
    endfunction

    // one +-1.0 per row and column, the rest zero
    function automatic t_matrix_word signed_perm_word();
        int           col [3];
        t_matrix_word w;
        col[0] = $urandom_range(0, 2);
        col[1] = (col[0] + 1 + $urandom_range(0, 1)) % 3;
        col[2] = 3 - col[0] - col[1];
        w = '0;
        for (int r = 0; r < 3; r++)
            w[(r*3 + col[r])*IN_W +: IN_W] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Driver side
    // ------------------------------------------------------------------------

    // send one matrix word; valid stays high when the next word follows at once
    task automatic send_matrix(input t_matrix_word w);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_quats.push_back(predict_quaternion(w));
    endtask

    // stop sending and wait until every queued quaternion has come out
    task automatic drain_quats();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_quats.size() != 0);
    endtask

    // write both registers while the pipeline is empty
    task automatic apply_config(input bit conv, input int thr);
        drain_quats();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= rmq_pkg::CFG_NEGATE_CONV;
        i_cfg_data  <= {7'($urandom_range(0, 127)), conv};
        do @(posedge i_clk); while (!o_cfg_ready);
        conv_neg = conv;
        i_cfg_index <= rmq_pkg::CFG_ZERO_THR;
        i_cfg_data  <= thr[rmq_pkg::CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        zero_thr = thr;
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls per word, with stall-free stretches
    // ------------------------------------------------------------------------
    initial begin : take_quats
        int stall;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = take_steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_quats
        t_quat got;
        t_quat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.scalar = m_axis_tdata[SW-1:0];
            got.qx     = m_axis_tdata[SW +: VW];
            got.qy     = m_axis_tdata[SW+VW +: VW];
            got.qz     = m_axis_tdata[SW+2*VW +: VW];
            got.bad    = m_axis_tuser[0];
            if (pending_quats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: quaternion with none expected: %s", $realtime,
                             quat_text(got));
            end else begin
                want = pending_quats.pop_front();
                if (got.scalar !== want.scalar || got.qx !== want.qx ||
                    got.qy !== want.qy || got.qz !== want.qz || got.bad !== want.bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: quaternion mismatch: expected %s, got %s",
                                 $realtime, quat_text(want), quat_text(got));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // identity, half turns, extreme and out-of-range entries
    task automatic test_special_matrices();
        apply_config(1'b0, 0);
        send_matrix(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(mat(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_matrix(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        // all entries at +1.0 and at -1.0
        send_matrix(mat(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        send_matrix(mat(-16384, -16384, -16384, -16384, -16384, -16384,
                        -16384, -16384, -16384));
        // full-scale words: saturated scalar, negative radicands
        send_matrix(mat(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_matrix(mat(-32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768));
        send_matrix(mat(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767));
        // quarter turns about z both ways: off-diagonal compare flips z
        send_matrix(mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send_matrix(mat(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
    endtask

    // negative convention, including a zero scalar that must not flip
    task automatic test_convention();
        apply_config(1'b1, 0);
        send_matrix(mat(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_matrix(mat(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_matrix(mat(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send_matrix(mat(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
    endtask

    // radicands of +-d around the largest threshold
    task automatic test_threshold();
        int d_list [6];
        apply_config(1'b0, 255);
        d_list = '{254, 255, -254, -255, 0, 256};
        foreach (d_list[i])
            send_matrix(mat(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384 + d_list[i]));
    endtask

    task automatic run_random_phase(input int n_items);
        int           pick;
        int           noise;
        t_matrix_word w;
        for (int i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                send_steady = ($urandom_range(0, 3) == 0);
                take_steady = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                case ($urandom_range(0, 2))
                    0:       noise = 0;
                    1:       noise = 3;
                    default: noise = 300;
                endcase
                w = rotation_word(noise);
            end else if (pick < 85) begin
                for (int k = 0; k < 9; k++)
                    w[k*IN_W +: IN_W] = 16'(int'($urandom_range(0, 32768)) - 16384);
            end else if (pick < 95) begin
                for (int k = 0; k < 9; k++) w[k*IN_W +: IN_W] = 16'($urandom());
            end else begin
                w = signed_perm_word();
            end
            send_matrix(w);
        end
        send_steady = 1'b0;
        take_steady = 1'b0;
    endtask

    // random matrices under several register settings
    task automatic test_random();
        apply_config(1'b0, 0);
        run_random_phase(80);
        // hold off until the pipeline has emptied, then carry on
        drain_quats();
        run_random_phase(80);
        apply_config(1'b1, 255);
        run_random_phase(160);
        apply_config(1'b0, 1);
        run_random_phase(150);
        apply_config(1'b1, 128);
        run_random_phase(150);
        apply_config(1'b0, 255);
        run_random_phase(140);
        apply_config(1'($urandom_range(0, 1)), $urandom_range(0, 255));
        run_random_phase(140);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        conv_neg      = 1'b0;
        zero_thr      = 0;
        mismatches    = 0;
        send_steady   = 1'b0;
        take_steady   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_matrices();
        test_convention();
        test_threshold();
        test_random();

        drain_quats();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS rotation_matrix_to_quaternion_unit");
        else
            $display("FAIL rotation_matrix_to_quaternion_unit");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL rotation_matrix_to_quaternion_unit");
        $finish;
    end

endmodule

/* sim.f */
rtl/rmq_pkg.sv
rtl/rmq_root_step.sv
rtl/rmq_lane.sv
rtl/rmq_merge.sv
rtl/rotation_matrix_to_quaternion_unit.sv
tb/sv/tb.sv
